// ===== src/gsga_pkg.sv =====
// Package for the grid symmetry gather-accumulate block.
// Holds the command, status, register index and sequencer state types.
// No dependencies.
package gsga_pkg;

  localparam int COORD_W    = 5;
  localparam int MESH_W     = 6;
  localparam int SHIFT_W    = 6;
  localparam int MATRIX_W   = 36;
  localparam int IO_VALUE_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int SUM_W      = 11;
  localparam int MAG_W      = 10;

  typedef enum logic [1:0] {
    CMD_LOAD_SRC = 2'd0,
    CMD_LOAD_ACC = 2'd1,
    CMD_APPLY    = 2'd2,
    CMD_READ_ACC = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_OUTSIDE = 2'd1,
    STATUS_SAT     = 2'd2,
    STATUS_SPARE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MESH_X   = 3'd0,
    REG_MESH_Y   = 3'd1,
    REG_MESH_Z   = 3'd2,
    REG_MATRIX   = 3'd3,
    REG_SHIFT_X  = 3'd4,
    REG_SHIFT_Y  = 3'd5,
    REG_SHIFT_Z  = 3'd6,
    REG_NONE     = 3'd7
  } cfg_index_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_MOD_HI = 8'b0000_0100,
    ST_MOD_LO = 8'b0000_1000,
    ST_GATHER = 8'b0001_0000,
    ST_ACCUM  = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_t;

endpackage

// ===== src/grid_symmetry_gather_accumulate.sv =====
// Top level of the grid symmetry gather-accumulate block.
// Holds the source and accumulator memories and the command sequencer.
// Depends on gsga_pkg.

// The block accepts one word at a time and returns exactly one result word for each.
// An apply command passes through acceptance, decode, the remainder states ST_MOD_HI and
// ST_MOD_LO (five compare-subtract steps each, on all three axes together), a gather read
// of both memories, the saturating write-back and the result state, which loads the output
// register once it is free. Loads into the accumulator grid and points outside the mesh go
// from decode to the result state; loads into the source grid and reads pass ST_READ first.
// The next word is accepted while a result still waits in the output register.
// Configuration writes are taken every cycle.
module grid_symmetry_gather_accumulate
  import gsga_pkg::*;
#(
  parameter int MAX_DIM     = 32,
  parameter int GRID_DEPTH  = 32768,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [MATRIX_W-1:0]         cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [COORD_W-1:0]          coord_x,
  input  logic [COORD_W-1:0]          coord_y,
  input  logic [COORD_W-1:0]          coord_z,
  input  logic signed [IO_VALUE_W-1:0] value_re,
  input  logic signed [IO_VALUE_W-1:0] value_im,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [IO_VALUE_W-1:0] result_re,
  output logic signed [IO_VALUE_W-1:0] result_im,
  output logic [1:0]                  status
);

  localparam int AW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int VW = VALUE_WIDTH;
  localparam int WW = ((VW > IO_VALUE_W) ? VW : IO_VALUE_W) + 1;
  localparam logic [31:0] MD32    = 32'(MAX_DIM);
  localparam logic [31:0] DEPTH32 = 32'(GRID_DEPTH);
  localparam logic signed [WW-1:0] VMAX = {{(WW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [WW-1:0] VMIN = ~VMAX;
  localparam logic signed [WW-1:0] OMAX = {{(WW-IO_VALUE_W+1){1'b0}}, {(IO_VALUE_W-1){1'b1}}};
  localparam logic signed [WW-1:0] OMIN = ~OMAX;

  function automatic logic [MESH_W-1:0] eff_mesh(input logic [MESH_W-1:0] r);
    if (r == '0) return MESH_W'(1);
    if (MAX_DIM < 64 && {3'b000, r} > 9'(MAX_DIM)) return MESH_W'(MAX_DIM);
    return r;
  endfunction

  function automatic logic [31:0] cell_idx(input logic [MESH_W-1:0] x,
                                           input logic [MESH_W-1:0] y,
                                           input logic [MESH_W-1:0] z);
    return ((32'(x) * MD32) + 32'(y)) * MD32 + 32'(z);
  endfunction

  function automatic logic signed [VW-1:0] clamp_in(input logic signed [IO_VALUE_W-1:0] v);
    logic signed [WW-1:0] e;
    e = WW'(v);
    if (e > VMAX) return VMAX[VW-1:0];
    if (e < VMIN) return VMIN[VW-1:0];
    return e[VW-1:0];
  endfunction

  function automatic logic signed [IO_VALUE_W-1:0] clamp_out(input logic signed [VW-1:0] v);
    logic signed [WW-1:0] e;
    e = WW'(v);
    if (e > OMAX) return OMAX[IO_VALUE_W-1:0];
    if (e < OMIN) return OMIN[IO_VALUE_W-1:0];
    return e[IO_VALUE_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mod_steps(input logic [MAG_W-1:0] r,
                                                 input logic [MESH_W-1:0] n,
                                                 input logic hi);
    logic [15:0] rem;
    logic [15:0] d;
    int k;
    rem = 16'(r);
    for (int j = 0; j < 5; j++) begin
      k = hi ? (9 - j) : (4 - j);
      d = 16'(n) << k;
      if (rem >= d) rem = rem - d;
    end
    return rem[MAG_W-1:0];
  endfunction

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   output logic sat);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    sat = s[VW] ^ s[VW-1];
    if (sat) return {s[VW], {(VW-1){~s[VW]}}};
    return s[VW-1:0];
  endfunction

  // Configuration registers.
  logic [MESH_W-1:0]   mesh_x, mesh_y, mesh_z;
  logic [MATRIX_W-1:0] rotation_matrix;
  logic [SHIFT_W-1:0]  shift_x, shift_y, shift_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_x          <= MESH_W'(1);
      mesh_y          <= MESH_W'(1);
      mesh_z          <= MESH_W'(1);
      rotation_matrix <= '0;
      shift_x         <= '0;
      shift_y         <= '0;
      shift_z         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        REG_MESH_X:  mesh_x          <= cfg_data[MESH_W-1:0];
        REG_MESH_Y:  mesh_y          <= cfg_data[MESH_W-1:0];
        REG_MESH_Z:  mesh_z          <= cfg_data[MESH_W-1:0];
        REG_MATRIX:  rotation_matrix <= cfg_data;
        REG_SHIFT_X: shift_x         <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Y: shift_y         <= cfg_data[SHIFT_W-1:0];
        REG_SHIFT_Z: shift_z         <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and latched item.
  state_t              state;
  command_t            cmd;
  logic [COORD_W-1:0]  cx, cy, cz;
  logic signed [VW-1:0] v_re, v_im;
  logic [MAG_W-1:0]    rem [3];
  logic                neg [3];
  logic [MESH_W-1:0]   mapped [3];
  logic signed [VW-1:0] res_re, res_im;
  status_t             res_status;

  logic [MESH_W-1:0]   eff [3];
  logic [SHIFT_W-1:0]  shift_v [3];
  logic signed [SUM_W-1:0] axis_sum [3];
  logic [MAG_W-1:0]    rem_hi [3];
  logic [MAG_W-1:0]    rem_lo [3];
  logic [MESH_W-1:0]   mapped_next [3];
  logic [31:0]         dst_idx, src_idx;
  logic                dst_ok, src_ok;
  logic [AW-1:0]       dst_addr, src_addr;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    eff[0]     = eff_mesh(mesh_x);
    eff[1]     = eff_mesh(mesh_y);
    eff[2]     = eff_mesh(mesh_z);
    shift_v[0] = shift_x;
    shift_v[1] = shift_y;
    shift_v[2] = shift_z;

    dst_idx  = cell_idx({1'b0, cx}, {1'b0, cy}, {1'b0, cz});
    dst_ok   = ({1'b0, cx} < eff[0]) && ({1'b0, cy} < eff[1]) &&
               ({1'b0, cz} < eff[2]) && (dst_idx < DEPTH32);
    dst_addr = dst_idx[AW-1:0];

    src_idx  = cell_idx(mapped[0], mapped[1], mapped[2]);
    src_ok   = (mapped[0] < eff[0]) && (mapped[1] < eff[1]) &&
               (mapped[2] < eff[2]) && (src_idx < DEPTH32);
    src_addr = src_idx[AW-1:0];

    for (int r = 0; r < 3; r++) begin
      axis_sum[r] =
        SUM_W'($signed(rotation_matrix[12*r +: 4])) * $signed({6'b0, cx}) +
        SUM_W'($signed(rotation_matrix[12*r + 4 +: 4])) * $signed({6'b0, cy}) +
        SUM_W'($signed(rotation_matrix[12*r + 8 +: 4])) * $signed({6'b0, cz}) +
        SUM_W'($signed(shift_v[r]));
      rem_hi[r] = mod_steps(rem[r], eff[r], 1'b1);
      rem_lo[r] = mod_steps(rem[r], eff[r], 1'b0);
      mapped_next[r] = (neg[r] && rem_lo[r] != '0) ?
                       (eff[r] - rem_lo[r][MESH_W-1:0]) : rem_lo[r][MESH_W-1:0];
    end
  end

  // Grid memories, each entry packed as {imaginary, real}.
  logic [2*VW-1:0] src_mem [GRID_DEPTH];
  logic [2*VW-1:0] acc_mem [GRID_DEPTH];
  logic [2*VW-1:0] src_rdata, acc_rdata;
  logic            src_we, acc_we;
  logic [2*VW-1:0] acc_wdata;
  logic signed [VW-1:0] new_re, new_im;
  logic            sat_re, sat_im;

  always_comb begin
    new_re = sat_add(acc_rdata[VW-1:0], src_rdata[VW-1:0], sat_re);
    new_im = sat_add(acc_rdata[2*VW-1:VW], src_rdata[2*VW-1:VW], sat_im);
    src_we = (state == ST_DECODE) && dst_ok && (cmd == CMD_LOAD_SRC);
    acc_we = ((state == ST_DECODE) && dst_ok && (cmd == CMD_LOAD_ACC)) ||
             (state == ST_ACCUM);
    acc_wdata = (state == ST_ACCUM) ? {new_im, new_re} : {v_im, v_re};
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[dst_addr] <= {v_im, v_re};
    src_rdata <= src_mem[src_addr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[dst_addr] <= acc_wdata;
    acc_rdata <= acc_mem[dst_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_RESULT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd   <= command_t'(command);
            cx    <= coord_x;
            cy    <= coord_y;
            cz    <= coord_z;
            v_re  <= clamp_in(value_re);
            v_im  <= clamp_in(value_im);
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          for (int r = 0; r < 3; r++) begin
            neg[r] <= axis_sum[r][SUM_W-1];
            rem[r] <= axis_sum[r][SUM_W-1] ? MAG_W'(-axis_sum[r]) : axis_sum[r][MAG_W-1:0];
          end
          if (!dst_ok) begin
            res_re     <= '0;
            res_im     <= '0;
            res_status <= STATUS_OUTSIDE;
            state      <= ST_RESULT;
          end else begin
            res_status <= STATUS_OK;
            unique case (cmd)
              CMD_LOAD_ACC: begin
                res_re <= v_re;
                res_im <= v_im;
                state  <= ST_RESULT;
              end
              CMD_APPLY:    state <= ST_MOD_HI;
              CMD_LOAD_SRC: state <= ST_READ;
              CMD_READ_ACC: state <= ST_READ;
            endcase
          end
        end
        ST_MOD_HI: begin
          for (int r = 0; r < 3; r++) rem[r] <= rem_hi[r];
          state <= ST_MOD_LO;
        end
        ST_MOD_LO: begin
          for (int r = 0; r < 3; r++) mapped[r] <= mapped_next[r];
          state <= ST_GATHER;
        end
        ST_GATHER: begin
          if (!src_ok) begin
            res_re     <= '0;
            res_im     <= '0;
            res_status <= STATUS_OUTSIDE;
            state      <= ST_RESULT;
          end else begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          res_re     <= new_re;
          res_im     <= new_im;
          res_status <= (sat_re || sat_im) ? STATUS_SAT : STATUS_OK;
          state      <= ST_RESULT;
        end
        ST_READ: begin
          res_re <= acc_rdata[VW-1:0];
          res_im <= acc_rdata[2*VW-1:VW];
          state  <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            result_re <= clamp_out(res_re);
            result_im <= clamp_out(res_im);
            status    <= res_status;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for grid_symmetry_gather_accumulate: predicts every result word
// from its own copy of both grids and the registers, and checks them in order.
// Depends on gsga_pkg and the block's top level.
`timescale 1ns / 100ps

module tb_top
  import gsga_pkg::*;
();

  localparam int GRID_DIM = 32;
  localparam int GRID_ENTRIES = 32768;
  localparam int CYCLE_LIMIT = 150000;
  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic [35:0] IDENTITY = 36'h1_0001_0001;
  localparam logic [35:0] ALL_NEG_EIGHT = 36'h8_8888_8888;

  typedef struct packed {
    command_t cmd;
    logic [4:0] x;
    logic [4:0] y;
    logic [4:0] z;
    logic signed [31:0] vre;
    logic signed [31:0] vim;
  } grid_word_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    status_t st;
  } grid_result_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = REG_MESH_X;
  logic [MATRIX_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  grid_word_t offered = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] result_re;
  logic signed [31:0] result_im;
  logic [1:0] status;

  cplx_t src_grid [GRID_ENTRIES];
  cplx_t acc_grid [GRID_ENTRIES];
  bit src_loaded [GRID_ENTRIES];
  bit acc_loaded [GRID_ENTRIES];
  logic [5:0] mesh_reg [3] = '{6'd1, 6'd1, 6'd1};
  logic [35:0] matrix_reg = '0;
  logic [5:0] shift_reg [3] = '{6'd0, 6'd0, 6'd0};

  grid_word_t word_queue [$];
  grid_result_t awaited_entries [$];
  int mismatches = 0;
  int cycle_count = 0;
  bit word_taken = 1'b0;
  bit calm = 1'b0;
  bit stall_armed = 1'b0;
  bit stall_done = 1'b0;
  int hold_left = 0;

  grid_symmetry_gather_accumulate u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (offered.cmd),
    .coord_x   (offered.x),
    .coord_y   (offered.y),
    .coord_z   (offered.z),
    .value_re  (offered.vre),
    .value_im  (offered.vim),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_re (result_re),
    .result_im (result_im),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int mesh_size(int axis);
    logic [5:0] r;
    r = mesh_reg[axis];
    if (r == 0) return 1;
    if (r > GRID_DIM) return GRID_DIM;
    return r;
  endfunction

  function automatic bit in_mesh(int x, int y, int z);
    return x < mesh_size(0) && y < mesh_size(1) && z < mesh_size(2);
  endfunction

  function automatic int entry_of(int x, int y, int z);
    return (x * GRID_DIM + y) * GRID_DIM + z;
  endfunction

  function automatic int mapped_coord(int row, int x, int y, int z);
    logic signed [3:0] k0, k1, k2;
    logic signed [5:0] sh;
    int s, n;
    k0 = matrix_reg[12*row +: 4];
    k1 = matrix_reg[12*row+4 +: 4];
    k2 = matrix_reg[12*row+8 +: 4];
    sh = shift_reg[row];
    n = mesh_size(row);
    s = k0 * x + k1 * y + k2 * z + sh;
    return ((s % n) + n) % n;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(VMAX)) return VMAX;
    if (v < longint'(VMIN)) return VMIN;
    return v[31:0];
  endfunction

  function automatic grid_result_t step_grids(grid_word_t w);
    grid_result_t r;
    int dst, src, mx, my, mz;
    longint sre, sim;
    logic signed [31:0] nre, nim;
    r = '0;
    r.st = STATUS_OK;
    if (!in_mesh(w.x, w.y, w.z)) begin
      r.st = STATUS_OUTSIDE;
      return r;
    end
    dst = entry_of(w.x, w.y, w.z);
    case (w.cmd)
      CMD_LOAD_SRC: begin
        src_grid[dst].re = w.vre;
        src_grid[dst].im = w.vim;
      end
      CMD_LOAD_ACC: begin
        acc_grid[dst].re = w.vre;
        acc_grid[dst].im = w.vim;
      end
      CMD_APPLY: begin
        mx = mapped_coord(0, w.x, w.y, w.z);
        my = mapped_coord(1, w.x, w.y, w.z);
        mz = mapped_coord(2, w.x, w.y, w.z);
        if (!in_mesh(mx, my, mz)) begin
          r.st = STATUS_OUTSIDE;
          return r;
        end
        src = entry_of(mx, my, mz);
        sre = longint'(acc_grid[dst].re) + longint'(src_grid[src].re);
        sim = longint'(acc_grid[dst].im) + longint'(src_grid[src].im);
        nre = sat32(sre);
        nim = sat32(sim);
        if (longint'(nre) != sre || longint'(nim) != sim) r.st = STATUS_SAT;
        acc_grid[dst].re = nre;
        acc_grid[dst].im = nim;
      end
      default: begin
      end
    endcase
    r.re = acc_grid[dst].re;
    r.im = acc_grid[dst].im;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_result();
    grid_result_t want;
    if (awaited_entries.size() == 0) begin
      report_mismatch("result word with no word pending");
    end else begin
      want = awaited_entries.pop_front();
      if (result_re !== want.re)
        report_mismatch($sformatf("result_re %0d, expected %0d", result_re, want.re));
      if (result_im !== want.im)
        report_mismatch($sformatf("result_im %0d, expected %0d", result_im, want.im));
      if (status !== want.st)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      word_taken = 1'b0;
      if (!rst) begin
        if (out_valid && out_ready) check_result();
        if (in_valid && in_ready) begin
          awaited_entries.push_back(step_grids(offered));
          word_taken = 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (word_queue.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
        offered <= word_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_armed && !stall_done) begin
        hold_left = 300;
        stall_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  task automatic write_register(cfg_index_t idx, logic [35:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MESH_X:  mesh_reg[0] = data[5:0];
      REG_MESH_Y:  mesh_reg[1] = data[5:0];
      REG_MESH_Z:  mesh_reg[2] = data[5:0];
      REG_MATRIX:  matrix_reg = data;
      REG_SHIFT_X: shift_reg[0] = data[5:0];
      REG_SHIFT_Y: shift_reg[1] = data[5:0];
      REG_SHIFT_Z: shift_reg[2] = data[5:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [35:0] pad6(logic [5:0] v);
    logic [35:0] d;
    d = {$urandom, 4'b0000};
    d[5:0] = v;
    return d;
  endfunction

  task automatic configure(logic [5:0] mx, logic [5:0] my, logic [5:0] mz,
                           logic [35:0] mat, logic [5:0] sx, logic [5:0] sy,
                           logic [5:0] sz);
    write_register(REG_MESH_X, pad6(mx));
    write_register(REG_MESH_Y, pad6(my));
    write_register(REG_MESH_Z, pad6(mz));
    write_register(REG_MATRIX, mat);
    write_register(REG_SHIFT_X, pad6(sx));
    write_register(REG_SHIFT_Y, pad6(sy));
    write_register(REG_SHIFT_Z, pad6(sz));
    @(posedge clk);
  endtask

  // A word that would read a grid entry never loaded is turned into, or preceded by,
  // the load of that entry.
  task automatic post_word(command_t c, int x, int y, int z,
                           logic signed [31:0] vre, logic signed [31:0] vim);
    grid_word_t w;
    int mx, my, mz;
    if (in_mesh(x, y, z)) begin
      if ((c == CMD_READ_ACC || c == CMD_APPLY) && !acc_loaded[entry_of(x, y, z)]) begin
        c = CMD_LOAD_ACC;
      end else if (c == CMD_APPLY) begin
        mx = mapped_coord(0, x, y, z);
        my = mapped_coord(1, x, y, z);
        mz = mapped_coord(2, x, y, z);
        if (!src_loaded[entry_of(mx, my, mz)]) begin
          c = CMD_LOAD_SRC;
          x = mx;
          y = my;
          z = mz;
        end
      end
      if (c == CMD_LOAD_SRC && !acc_loaded[entry_of(x, y, z)]) begin
        acc_loaded[entry_of(x, y, z)] = 1'b1;
        w.cmd = CMD_LOAD_ACC;
        w.x = x[4:0];
        w.y = y[4:0];
        w.z = z[4:0];
        w.vre = vre;
        w.vim = vim;
        word_queue.push_back(w);
      end
      if (c == CMD_LOAD_SRC) src_loaded[entry_of(x, y, z)] = 1'b1;
      if (c == CMD_LOAD_ACC) acc_loaded[entry_of(x, y, z)] = 1'b1;
    end
    w.cmd = c;
    w.x = x[4:0];
    w.y = y[4:0];
    w.z = z[4:0];
    w.vre = vre;
    w.vim = vim;
    word_queue.push_back(w);
  endtask

  function automatic command_t pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_APPLY;
    if (r < 60) return CMD_LOAD_SRC;
    if (r < 75) return CMD_LOAD_ACC;
    return CMD_READ_ACC;
  endfunction

  function automatic int pick_coord(int axis);
    int r, n;
    r = $urandom_range(99);
    n = mesh_size(axis);
    if (r < 8) return $urandom_range(31);
    if (r < 16) return $urandom_range(n > 31 ? 31 : n);
    return $urandom_range((n > 5 ? 5 : n) - 1);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 15) return VMAX;
    if (r < 30) return VMIN;
    if (r < 70) return $urandom;
    return int'($urandom_range(1048576)) - 524288;
  endfunction

  function automatic logic [5:0] pick_mesh();
    int r;
    r = $urandom_range(9);
    if (r < 7) return 6'($urandom_range(6, 1));
    if (r < 9) return 6'($urandom_range(63));
    return 6'd32;
  endfunction

  function automatic logic [35:0] pick_matrix();
    logic [35:0] m;
    m[31:0] = $urandom;
    m[35:32] = 4'($urandom_range(15));
    return m;
  endfunction

  task automatic wait_idle();
    while (word_queue.size() != 0 || in_valid || awaited_entries.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(6'd4, 6'd3, 6'd5, IDENTITY, 6'd0, 6'd0, 6'd0);
    post_word(CMD_LOAD_SRC, 0, 0, 0, VMAX, VMIN);
    post_word(CMD_LOAD_ACC, 0, 0, 0, 1, -1);
    post_word(CMD_APPLY, 0, 0, 0, 0, 0);
    post_word(CMD_READ_ACC, 0, 0, 0, 0, 0);
    post_word(CMD_LOAD_SRC, 3, 2, 4, -5, 7);
    post_word(CMD_LOAD_ACC, 3, 2, 4, 100, -100);
    post_word(CMD_APPLY, 3, 2, 4, 0, 0);
    post_word(CMD_APPLY, 3, 2, 4, 0, 0);
    post_word(CMD_LOAD_ACC, 1, 1, 1, VMIN, VMAX);
    post_word(CMD_LOAD_SRC, 1, 1, 1, -1, 1);
    post_word(CMD_APPLY, 1, 1, 1, 0, 0);
    post_word(CMD_READ_ACC, 4, 0, 0, 0, 0);
    post_word(CMD_LOAD_SRC, 0, 3, 0, VMAX, VMAX);
    post_word(CMD_LOAD_ACC, 0, 0, 5, VMIN, VMIN);
    post_word(CMD_APPLY, 31, 31, 31, 0, 0);
    wait_idle();

    write_register(REG_NONE, {$urandom, 4'b1010});
    configure(6'd0, 6'd63, 6'd32, ALL_NEG_EIGHT, 6'h20, 6'h1F, 6'h3F);
    repeat (3) post_word(CMD_APPLY, 0, 31, 31, VMAX, VMIN);
    repeat (3) post_word(CMD_APPLY, 0, 0, 0, -3, 9);
    post_word(CMD_READ_ACC, 0, 31, 31, 0, 0);
    post_word(CMD_LOAD_SRC, 1, 0, 0, -1, -1);
    post_word(CMD_APPLY, 0, 17, 3, 0, 0);
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      if (phase == 5)
        configure(6'd32, 6'd32, 6'd32, pick_matrix(), 6'($urandom_range(63)),
                  6'($urandom_range(63)), 6'($urandom_range(63)));
      else
        configure(pick_mesh(), pick_mesh(), pick_mesh(), pick_matrix(),
                  6'($urandom_range(63)), 6'($urandom_range(63)),
                  6'($urandom_range(63)));
      calm = (phase == 1);
      stall_armed = (phase == 3);
      repeat (100)
        post_word(pick_command(), pick_coord(0), pick_coord(1), pick_coord(2),
                  pick_value(), pick_value());
      wait_idle();
    end
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
